@@ rtl/grc_pkg.sv @@
// Shared constants, codes and helper functions of the column raycaster.
`timescale 1ns / 1ps
package grc_pkg;

  localparam int MAP_DIM   = 32;
  localparam int MAX_STEPS = 64;

  localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  // map coordinate, two's complement, wide enough for a start cell of 0..31 plus one step
  localparam int MC_W      = (($clog2(MAP_DIM) > 5) ? $clog2(MAP_DIM) : 5) + 2;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int CAM_W  = 26;
  localparam int PROD_W = CAM_W + 16;
  localparam int RAY_W  = 28;
  localparam int ABS_W  = RAY_W - 1;
  localparam int PW     = $clog2(65536 * (MAX_STEPS + 1) + 1) + ABS_W;
  localparam int SD_W   = ((MC_W + 16 > 22) ? MC_W + 16 : 22) + 1;
  localparam int NUM_W  = 11 + ABS_W + 2;
  localparam int DEN_W  = SD_W - 1;
  localparam int LH_W   = 25;
  localparam logic [LH_W-1:0] LH_SAT = LH_W'(1 << 24);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 3'd7;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [MC_W-1:0] x,
                                                  input logic [MC_W-1:0] y);
    return ADDR_W'(x) * ADDR_W'(MAP_DIM) + ADDR_W'(y);
  endfunction

  // packed {red, green, blue}
  function automatic logic [23:0] wall_color(input logic [2:0] t);
    logic [23:0] c;
    case (t)
      3'd1: c = {8'd116, 8'd67, 8'd53};
      3'd2: c = {8'd100, 8'd151, 8'd79};
      3'd3: c = {8'd64, 8'd50, 8'd133};
      3'd4: c = {8'd255, 8'd255, 8'd255};
      default: c = {8'd123, 8'd72, 8'd144};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/grc_if.sv @@
// Channel interfaces: command in, stripe out, register writes.
`timescale 1ns / 1ps
interface grc_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [9:0] column;
  logic [4:0] cell_x;
  logic [4:0] cell_y;
  logic [2:0] cell_value;
  modport source (output valid, opcode, column, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, opcode, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface grc_stripe_if;
  logic       valid;
  logic       ready;
  logic [9:0] stripe_column;
  logic [9:0] draw_start;
  logic [9:0] draw_end;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       hit_side;
  logic [2:0] wall_type;
  modport source (output valid, stripe_column, draw_start, draw_end, red, green, blue,
                  hit_side, wall_type, input ready);
  modport sink   (input valid, stripe_column, draw_start, draw_end, red, green, blue,
                  hit_side, wall_type, output ready);
endinterface

interface grc_cfg_if import grc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/grc_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grc_div import grc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quo[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_q};
    rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

@@ rtl/grid_raycast_column.sv @@
// Top level of the column raycaster: registers, map memory, cast sequencer.
`timescale 1ns / 1ps
// Casts one ray per screen column through a MAP_DIM x MAP_DIM map by DDA and returns the wall
// stripe for it. After reset the map memory is cleared one cell a cycle (MAP_DEPTH = 1024
// cells) and no command is taken meanwhile; register writes are always taken. A cast runs
// one serial divide for the camera x value, one step and one read-and-test of the map memory
// per cell walked (at most MAX_STEPS cells), and one serial divide for the line height. One
// command is worked on at a time; a finished stripe waits in the output register while the
// next command is taken.
module grid_raycast_column import grc_pkg::*; (
  input logic     clk,
  input logic     rst,
  grc_cfg_if.sink cfg,
  grc_cmd_if.sink cmd,
  grc_stripe_if.source stripe
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_CAMDV = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_RAY   = 11'b00000010000,
    S_INIT  = 11'b00000100000,
    S_WALK  = 11'b00001000000,
    S_READ  = 11'b00010000000,
    S_DIST  = 11'b00100000000,
    S_LHDV  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state;

  logic [20:0]        pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [10:0]        screen_width, screen_height;
  logic [10:0]        w_eff, h_eff;

  logic [2:0]  wall_map [MAP_DEPTH];
  logic [2:0]  rd_data;
  logic [ADDR_W-1:0] raddr, waddr, clr_cnt;
  logic        we;
  logic [2:0]  wdata;

  logic [9:0]               col;
  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [RAY_W-1:0]         rx, ry;
  logic [ABS_W-1:0]         arx, ary;
  logic                     sx_neg, sy_neg;
  logic [16:0]              nx0, ny0;
  logic [PW-1:0]            p_acc, q_acc;
  logic [MC_W-1:0]          mx, my, mx_n, my_n;
  logic [STEP_W-1:0]        n;
  logic                     side, stepx, oob;
  logic [2:0]               wtype;
  logic [LH_W-1:0]          lh;

  logic [MC_W-1:0]  base;
  logic [SD_W-1:0]  diff;
  logic [DEN_W-1:0] d_abs;
  logic [ABS_W-1:0] a_sel;
  logic [37:0]      hprod;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  logic [9:0]      hs, ds, de, hm1;
  logic [LH_W-2:0] lhh;
  logic [LH_W-1:0] hsum;
  logic [23:0]     rgb;

  logic cmd_xfer, cast_xfer, wr_ok;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cast_xfer = cmd_xfer && (cmd.opcode == OP_CAST);
  assign wr_ok     = cmd_xfer && (cmd.opcode == OP_WRITE) &&
                     (MC_W'(cmd.cell_x) < MC_W'(MAP_DIM)) && (MC_W'(cmd.cell_y) < MC_W'(MAP_DIM));

  assign w_eff = (screen_width == 11'd0) ? 11'd1 : screen_width;
  assign h_eff = (screen_height == 11'd0) ? 11'd1 :
                 (screen_height > 11'd1024) ? 11'd1024 : screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= 21'd786432;
      pos_y         <= 21'd786432;
      dir_x         <= -16'sd16384;
      dir_y         <= 16'sd0;
      plane_x       <= 16'sd0;
      plane_y       <= 16'sd10813;
      screen_width  <= 11'd512;
      screen_height <= 11'd384;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POS_X:   pos_x         <= cfg.data;
        REG_POS_Y:   pos_y         <= cfg.data;
        REG_DIR_X:   dir_x         <= cfg.data[15:0];
        REG_DIR_Y:   dir_y         <= cfg.data[15:0];
        REG_PLANE_X: plane_x       <= cfg.data[15:0];
        REG_PLANE_Y: plane_y       <= cfg.data[15:0];
        REG_SCR_W:   screen_width  <= cfg.data[10:0];
        REG_SCR_H:   screen_height <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // map memory: one write port, one registered read port
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = 3'd0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (wr_ok) begin
      we    = 1'b1;
      waddr = cell_addr(MC_W'(cmd.cell_x), MC_W'(cmd.cell_y));
      wdata = cmd.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wall_map[waddr] <= wdata;
    end
    rd_data <= wall_map[raddr];
  end

  // one DDA step
  always_comb begin
    if (arx == '0) begin
      stepx = 1'b0;
    end else if (ary == '0) begin
      stepx = 1'b1;
    end else begin
      stepx = p_acc < q_acc;
    end
    mx_n = mx;
    my_n = my;
    if (stepx) begin
      mx_n = sx_neg ? mx - MC_W'(1) : mx + MC_W'(1);
    end else begin
      my_n = sy_neg ? my - MC_W'(1) : my + MC_W'(1);
    end
    oob = mx_n[MC_W-1] || my_n[MC_W-1] ||
          (mx_n >= MC_W'(MAP_DIM)) || (my_n >= MC_W'(MAP_DIM));
    raddr = cell_addr(mx_n, my_n);
  end

  // hit distance and height numerator
  always_comb begin
    base  = side ? my + MC_W'(sy_neg) : mx + MC_W'(sx_neg);
    diff  = {{(SD_W - MC_W - 16){base[MC_W-1]}}, base, 16'd0} - SD_W'(pos_x);
    if (side) begin
      diff = {{(SD_W - MC_W - 16){base[MC_W-1]}}, base, 16'd0} - SD_W'(pos_y);
    end
    d_abs = diff[SD_W-1] ? DEN_W'(-diff) : DEN_W'(diff);
    a_sel = side ? ary : arx;
    hprod = 38'(h_eff) * 38'(a_sel);
  end

  assign div_start = cast_xfer || ((state == S_DIST) && (d_abs != '0));
  assign div_num   = (state == S_IDLE) ? NUM_W'({cmd.column, 15'd0}) : {hprod, 2'b00};
  assign div_den   = (state == S_IDLE) ? DEN_W'(w_eff) : d_abs;

  grc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // stripe rows and shading
  always_comb begin
    hs   = h_eff[10:1];
    hm1  = 10'(h_eff - 11'd1);
    lhh  = lh[LH_W-1:1];
    ds   = (lhh >= (LH_W-1)'(hs)) ? 10'd0 : 10'(hs - lhh[9:0]);
    hsum = LH_W'(hs) + LH_W'(lhh);
    de   = (hsum > LH_W'(hm1)) ? hm1 : hsum[9:0];
    rgb  = wall_color(wtype);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      stripe.valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!stripe.valid || stripe.ready)) begin
        stripe.valid <= 1'b1;
      end else if (stripe.valid && stripe.ready) begin
        stripe.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cast_xfer) begin
            state <= S_CAMDV;
          end
        end
        S_CAMDV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_RAY;
        S_RAY:  state <= S_INIT;
        S_INIT: state <= S_WALK;
        S_WALK: begin
          state <= oob ? S_DIST : S_READ;
        end
        S_READ: begin
          if ((rd_data != 3'd0) || (n == STEP_W'(MAX_STEPS))) begin
            state <= S_DIST;
          end else begin
            state <= S_WALK;
          end
        end
        S_DIST: begin
          state <= (d_abs == '0) ? S_EMIT : S_LHDV;
        end
        S_LHDV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!stripe.valid || stripe.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rx = RAY_W'(prod_x >>> 14) + RAY_W'(dir_x);
  assign ry = RAY_W'(prod_y >>> 14) + RAY_W'(dir_y);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col <= cmd.column;
      end
      S_CAMDV: begin
        cam <= $signed({1'b0, div_quo[CAM_W-2:0]}) - CAM_W'(16384);
      end
      S_MUL: begin
        prod_x <= PROD_W'(plane_x) * PROD_W'(cam);
        prod_y <= PROD_W'(plane_y) * PROD_W'(cam);
      end
      S_RAY: begin
        arx    <= rx[RAY_W-1] ? ABS_W'(-rx) : ABS_W'(rx);
        ary    <= ry[RAY_W-1] ? ABS_W'(-ry) : ABS_W'(ry);
        sx_neg <= rx[RAY_W-1];
        sy_neg <= ry[RAY_W-1];
        nx0    <= rx[RAY_W-1] ? {1'b0, pos_x[15:0]} : 17'h10000 - 17'(pos_x[15:0]);
        ny0    <= ry[RAY_W-1] ? {1'b0, pos_y[15:0]} : 17'h10000 - 17'(pos_y[15:0]);
        mx     <= MC_W'(pos_x[20:16]);
        my     <= MC_W'(pos_y[20:16]);
      end
      S_INIT: begin
        p_acc <= PW'(nx0) * PW'(ary);
        q_acc <= PW'(ny0) * PW'(arx);
        n     <= '0;
      end
      S_WALK: begin
        mx   <= mx_n;
        my   <= my_n;
        n    <= n + STEP_W'(1);
        side <= !stepx;
        if (stepx) begin
          p_acc <= p_acc + {ary, 16'd0};
        end else begin
          q_acc <= q_acc + {arx, 16'd0};
        end
        if (oob) begin
          wtype <= 3'd1;
        end
      end
      S_READ: begin
        wtype <= (rd_data != 3'd0) ? rd_data : 3'd1;
      end
      S_DIST: begin
        if (d_abs == '0) begin
          lh <= LH_SAT;
        end
      end
      S_LHDV: begin
        if (div_done) begin
          lh <= (div_quo > NUM_W'(LH_SAT)) ? LH_SAT : div_quo[LH_W-1:0];
        end
      end
      S_EMIT: begin
        if (!stripe.valid || stripe.ready) begin
          stripe.stripe_column <= col;
          stripe.draw_start    <= ds;
          stripe.draw_end      <= de;
          stripe.red           <= side ? {1'b0, rgb[23:17]} : rgb[23:16];
          stripe.green         <= side ? {1'b0, rgb[15:9]}  : rgb[15:8];
          stripe.blue          <= side ? {1'b0, rgb[7:1]}   : rgb[7:0];
          stripe.hit_side      <= side;
          stripe.wall_type     <= wtype;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/grc_checker.sv @@
// Port-level checks of the column raycaster and their bind to the top level.
`timescale 1ns / 1ps
module grc_checker import grc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] draw_start,
  input logic [9:0] draw_end
);

  // no stripe right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("stripe valid right after reset");

  // a cast occupies the block: no command taken in the next cycle
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_opcode == OP_CAST)) |=> !in_ready)
    else $error("command taken right after a cast");

  // stripe rows are ordered
  a_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (draw_start <= draw_end))
    else $error("draw_start beyond draw_end");

  // a stalled stripe holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(draw_start) && $stable(draw_end)))
    else $error("stalled stripe changed");

endmodule

bind grid_raycast_column grc_checker u_grc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd.valid),
  .in_ready   (cmd.ready),
  .in_opcode  (cmd.opcode),
  .out_valid  (stripe.valid),
  .out_ready  (stripe.ready),
  .draw_start (stripe.draw_start),
  .draw_end   (stripe.draw_end)
);
